@@ hdl/cspt_pkg.sv @@
`default_nettype none

package cspt_pkg;

	// Fixed field widths of the command and response words
	localparam int OP_W      = 2;
	localparam int FUNC_ID_W = 6;
	localparam int TS_W      = 48;
	localparam int STATUS_W  = 3;

	// Operation codes; the spare code behaves as a read
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_END   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADID     = 3'd4;

	// Configuration register indexes
	localparam int REG_ACC_MODE = 0;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [FUNC_ID_W-1:0] func_id;
		logic [TS_W-1:0]      timestamp;
	} cmd_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TS_W-1:0]     acc_time;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_ACC,
		S_WSTK,
		S_WADD,
		S_DONE
	} state_t;

	typedef enum logic {
		ALU_SUB_CLAMP,
		ALU_ADD_SAT
	} alu_op_t;

	// Operand pairs fed to the shared time unit
	typedef enum logic [1:0] {
		SRC_ELAPSED,   // now - start
		SRC_TOTAL,     // total + elapsed
		SRC_WALK       // caller start + elapsed
	} alu_src_t;

	// Conditions seen by the sequencer
	typedef struct packed {
		logic cmd_fire;
		logic bad_id;
		logic op_begin;
		logic op_end;
		logic excl;
		logic stack_full;
		logic stack_empty;
		logic top_match;
		logic one_left;
		logic last_walk;
		logic last_clear;
		logic out_free;
	} flags_t;

	// Actions driven by the sequencer
	typedef struct packed {
		logic                ready;
		logic                clear_wr;
		logic                eval;
		logic                begin_wr;
		logic                push;
		logic                acc_upd;
		logic                pop;
		logic                walk_first;
		logic                walk_rd;
		logic                walk_wr;
		logic                out_load;
		logic [STATUS_W-1:0] status;
		alu_op_t             alu_op;
		alu_src_t            alu_src;
	} ctrl_t;

endpackage

`default_nettype wire

@@ hdl/cspt_alu.sv @@
`default_nettype none

module cspt_alu #(
	parameter int W = 48
) (
	input  wire cspt_pkg::alu_op_t op,
	input  wire logic [W-1:0]      a,
	input  wire logic [W-1:0]      b,
	output logic [W-1:0]           y
);

	logic         sub;
	logic [W-1:0] b_x;
	logic [W:0]   sum;
	logic         carry;

	// One adder serves both: a + ~b + 1 carries out exactly when a >= b
	assign sub   = (op == cspt_pkg::ALU_SUB_CLAMP);
	assign b_x   = sub ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_x} + (W+1)'(sub);
	assign carry = sum[W];

	always_comb begin
		unique case (op)
			cspt_pkg::ALU_SUB_CLAMP: y = carry ? sum[W-1:0] : '0;
			cspt_pkg::ALU_ADD_SAT:   y = carry ? '1 : sum[W-1:0];
			default:                 y = sum[W-1:0];
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/cspt_seq.sv @@
`default_nettype none

module cspt_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cspt_pkg::flags_t flags,
	output cspt_pkg::ctrl_t       ctrl
);

	cspt_pkg::state_t state_q;
	cspt_pkg::state_t state_d;
	logic [cspt_pkg::STATUS_W-1:0] eval_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cspt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Outcome of an item, decided from the looked-up entries
	always_comb begin
		priority if (flags.bad_id) begin
			eval_status = cspt_pkg::ST_BADID;
		end else if (flags.op_begin && flags.excl && flags.stack_full) begin
			eval_status = cspt_pkg::ST_OVERFLOW;
		end else if (flags.op_end && flags.excl && flags.stack_empty) begin
			eval_status = cspt_pkg::ST_UNDERFLOW;
		end else if (flags.op_end && flags.excl && !flags.top_match) begin
			eval_status = cspt_pkg::ST_MISMATCH;
		end else begin
			eval_status = cspt_pkg::ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cspt_pkg::S_CLEAR: begin
				if (flags.last_clear) state_d = cspt_pkg::S_IDLE;
			end
			cspt_pkg::S_IDLE: begin
				if (flags.cmd_fire) state_d = cspt_pkg::S_READ;
			end
			cspt_pkg::S_READ: begin
				state_d = cspt_pkg::S_EVAL;
			end
			cspt_pkg::S_EVAL: begin
				if (eval_status == cspt_pkg::ST_OK && flags.op_end) begin
					state_d = cspt_pkg::S_ACC;
				end else begin
					state_d = cspt_pkg::S_DONE;
				end
			end
			cspt_pkg::S_ACC: begin
				if (flags.excl && !flags.one_left) begin
					state_d = cspt_pkg::S_WSTK;
				end else begin
					state_d = cspt_pkg::S_DONE;
				end
			end
			cspt_pkg::S_WSTK: begin
				state_d = cspt_pkg::S_WADD;
			end
			cspt_pkg::S_WADD: begin
				if (flags.last_walk) begin
					state_d = cspt_pkg::S_DONE;
				end else begin
					state_d = cspt_pkg::S_WSTK;
				end
			end
			cspt_pkg::S_DONE: begin
				if (flags.out_free) state_d = cspt_pkg::S_IDLE;
			end
			default: state_d = cspt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl         = '0;
		ctrl.status  = eval_status;
		ctrl.alu_op  = cspt_pkg::ALU_ADD_SAT;
		ctrl.alu_src = cspt_pkg::SRC_TOTAL;
		unique case (state_q)
			cspt_pkg::S_CLEAR: begin
				ctrl.clear_wr = 1'b1;
			end
			cspt_pkg::S_IDLE: begin
				ctrl.ready = 1'b1;
			end
			cspt_pkg::S_READ: begin
			end
			cspt_pkg::S_EVAL: begin
				ctrl.eval     = 1'b1;
				ctrl.alu_op   = cspt_pkg::ALU_SUB_CLAMP;
				ctrl.alu_src  = cspt_pkg::SRC_ELAPSED;
				ctrl.begin_wr = flags.op_begin && !flags.bad_id
					&& !(flags.excl && flags.stack_full);
				ctrl.push     = flags.op_begin && !flags.bad_id
					&& flags.excl && !flags.stack_full;
			end
			cspt_pkg::S_ACC: begin
				ctrl.acc_upd    = 1'b1;
				ctrl.pop        = flags.excl;
				ctrl.walk_first = 1'b1;
			end
			cspt_pkg::S_WSTK: begin
				ctrl.walk_rd = 1'b1;
			end
			cspt_pkg::S_WADD: begin
				ctrl.walk_wr = 1'b1;
				ctrl.alu_src = cspt_pkg::SRC_WALK;
			end
			cspt_pkg::S_DONE: begin
				ctrl.out_load = flags.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/call_stack_self_time_profiler.sv @@
`default_nettype none

// Channel  Direction  Handshake           Word
// cmd      in         cmd_valid/cmd_stall cspt_pkg::cmd_word_t (op, func_id, timestamp)
// rsp      out        rsp_valid/rsp_stall cspt_pkg::rsp_word_t (status, acc_time)
// apb      in         psel/penable/pready accumulate_mode at word 0
//
// Begin, read and every error pass the read, evaluate and done steps; an end also
// updates the total, and an exclusive end then walks each caller left on the
// stack: the shared time adder and single table ports cost a read and an add per caller.
// After reset a clearing pass over all NUM_FUNCTIONS entries zeroes both time tables;
// cmd_stall stays high meanwhile while register writes are still taken.
// A held rsp word blocks only the final step of the next item.

module call_stack_self_time_profiler #(
	parameter int NUM_FUNCTIONS = 64,
	parameter int STACK_DEPTH   = 16,
	parameter int TIME_BITS     = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire cspt_pkg::cmd_word_t cmd_word,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output cspt_pkg::rsp_word_t      rsp_word,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int IDW = $clog2(NUM_FUNCTIONS);
	localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW  = $clog2(STACK_DEPTH + 1);

	cspt_pkg::flags_t flags;
	cspt_pkg::ctrl_t  ctrl;

	// Configuration
	logic acc_mode_q;
	logic reg_sel;
	logic cfg_wr;

	// Item being worked on
	logic                     cmd_fire;
	logic [cspt_pkg::OP_W-1:0] op_q;
	logic [IDW-1:0]           id_q;
	logic                     bad_q;
	logic [TIME_BITS-1:0]     now_q;
	logic [TIME_BITS-1:0]     elapsed_q;

	// Stack bookkeeping and sweep counters
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  walk_k_q;
	logic [CW-1:0]  walk_next;
	logic [IDW-1:0] clr_idx_q;

	// Tables
	logic [TIME_BITS-1:0] start_mem [NUM_FUNCTIONS];
	logic [TIME_BITS-1:0] total_mem [NUM_FUNCTIONS];
	logic [IDW-1:0]       stack_mem [STACK_DEPTH];
	logic [TIME_BITS-1:0] start_rd_q;
	logic [TIME_BITS-1:0] total_rd_q;
	logic [IDW-1:0]       stack_rd_q;

	logic                 st_we;
	logic [IDW-1:0]       st_wa;
	logic [TIME_BITS-1:0] st_wd;
	logic [IDW-1:0]       st_ra;
	logic                 tot_we;
	logic [IDW-1:0]       tot_a;
	logic [TIME_BITS-1:0] tot_wd;
	logic [SW-1:0]        stk_ra;

	// Shared time unit
	logic [TIME_BITS-1:0] alu_a;
	logic [TIME_BITS-1:0] alu_b;
	logic [TIME_BITS-1:0] alu_y;

	// Result and output register
	logic [cspt_pkg::STATUS_W-1:0] res_status_q;
	logic [TIME_BITS-1:0]          res_total_q;
	logic                          rsp_valid_q;
	cspt_pkg::rsp_word_t           rsp_word_q;

	// ---------------------------------------------------------------
	// Register port: always ready, word address in paddr[2]
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == 1'(cspt_pkg::REG_ACC_MODE));
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? 32'(acc_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			acc_mode_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign cmd_stall = !ctrl.ready;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign walk_next = walk_k_q + CW'(1);

	always_comb begin
		flags             = '0;
		flags.cmd_fire    = cmd_fire;
		flags.bad_id      = bad_q;
		flags.op_begin    = (op_q == cspt_pkg::OP_BEGIN);
		flags.op_end      = (op_q == cspt_pkg::OP_END);
		flags.excl        = !acc_mode_q;
		flags.stack_full  = (cnt_q >= CW'(STACK_DEPTH));
		flags.stack_empty = (cnt_q == '0);
		flags.top_match   = (stack_rd_q == id_q);
		flags.one_left    = (cnt_q == CW'(1));
		flags.last_walk   = (walk_next == cnt_q);
		flags.last_clear  = (clr_idx_q == IDW'(NUM_FUNCTIONS - 1));
		flags.out_free    = !rsp_valid_q || !rsp_stall;
	end

	cspt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// ---------------------------------------------------------------
	// Capture the command word; mask the time to TIME_BITS and check the id
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q  <= cmd_word.op;
			id_q  <= IDW'(cmd_word.func_id);
			now_q <= TIME_BITS'(cmd_word.timestamp);
			bad_q <= (cmd_word.func_id == '0)
				|| (32'(cmd_word.func_id) >= 32'(NUM_FUNCTIONS));
		end
	end

	// ---------------------------------------------------------------
	// Clearing pass and stack pointers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			cnt_q     <= '0;
			walk_k_q  <= '0;
		end else begin
			if (ctrl.clear_wr) clr_idx_q <= clr_idx_q + IDW'(1);
			if (ctrl.push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctrl.pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (ctrl.walk_first) begin
				walk_k_q <= '0;
			end else if (ctrl.walk_wr) begin
				walk_k_q <= walk_next;
			end
		end
	end

	// ---------------------------------------------------------------
	// Shared time unit: elapsed on eval, total on update, caller start on walk
	// ---------------------------------------------------------------
	always_comb begin
		unique case (ctrl.alu_src)
			cspt_pkg::SRC_ELAPSED: begin
				alu_a = now_q;
				alu_b = start_rd_q;
			end
			cspt_pkg::SRC_TOTAL: begin
				alu_a = total_rd_q;
				alu_b = elapsed_q;
			end
			cspt_pkg::SRC_WALK: begin
				alu_a = start_rd_q;
				alu_b = elapsed_q;
			end
			default: begin
				alu_a = total_rd_q;
				alu_b = elapsed_q;
			end
		endcase
	end

	cspt_alu #(
		.W (TIME_BITS)
	) u_alu (
		.op (ctrl.alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// ---------------------------------------------------------------
	// Start-time table: zero on clear, stamp on begin, shift callers on walk
	// ---------------------------------------------------------------
	always_comb begin
		st_we = ctrl.clear_wr || ctrl.begin_wr || ctrl.walk_wr;
		st_ra = ctrl.walk_rd ? stack_rd_q : id_q;
		priority if (ctrl.clear_wr) begin
			st_wa = clr_idx_q;
			st_wd = '0;
		end else if (ctrl.begin_wr) begin
			st_wa = id_q;
			st_wd = now_q;
		end else begin
			st_wa = stack_rd_q;
			st_wd = alu_y;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) start_mem[st_wa] <= st_wd;
		start_rd_q <= start_mem[st_ra];
	end

	// ---------------------------------------------------------------
	// Accumulated-time table
	// ---------------------------------------------------------------
	assign tot_we = ctrl.clear_wr || ctrl.acc_upd;
	assign tot_a  = ctrl.clear_wr ? clr_idx_q : id_q;
	assign tot_wd = ctrl.clear_wr ? '0 : alu_y;

	always_ff @(posedge clk) begin
		if (tot_we) total_mem[tot_a] <= tot_wd;
		total_rd_q <= total_mem[tot_a];
	end

	// ---------------------------------------------------------------
	// Call stack: top on lookup, bottom first on walk, then one up per step;
	// hold the caller id while its start time is fetched
	// ---------------------------------------------------------------
	always_comb begin
		priority if (ctrl.walk_first) begin
			stk_ra = '0;
		end else if (ctrl.walk_rd) begin
			stk_ra = SW'(walk_k_q);
		end else if (ctrl.walk_wr) begin
			stk_ra = SW'(walk_next);
		end else begin
			stk_ra = SW'(cnt_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) stack_mem[SW'(cnt_q)] <= id_q;
		stack_rd_q <= stack_mem[stk_ra];
	end

	// ---------------------------------------------------------------
	// Result: hold status and total until the output register is free
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			res_status_q <= ctrl.status;
			res_total_q  <= bad_q ? '0 : total_rd_q;
			elapsed_q    <= alu_y;
		end else if (ctrl.acc_upd) begin
			res_total_q <= alu_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			rsp_word_q.status   <= res_status_q;
			rsp_word_q.acc_time <= cspt_pkg::TS_W'(res_total_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

`default_nettype wire
